@@ sv/irb_pkg.sv @@
// Shared constants, register codes and transfer types of the rotation core.
`default_nettype none
package irb_pkg;

    localparam int DEF_MAX_SRC_HEIGHT  = 256;
    localparam int DEF_MAX_SRC_WIDTH   = 256;
    localparam int DEF_COORD_FRAC_BITS = 8;

    localparam int TRIG_FRAC = 14;   // fraction bits of the cosine and sine registers
    localparam int SIZE_W    = 13;   // holds any source size up to 4096
    localparam int FRAC_MAX  = 16;   // widest coordinate fraction
    localparam int Q_DEPTH   = 8;    // job queue between front and back
    localparam int OUT_DEPTH = 8;    // result queue

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COSINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SINE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // One classified item, front to back.
    typedef struct packed {
        logic                is_write;
        logic [8:0]          row;
        logic [8:0]          col;
        logic                bg;
        logic [SIZE_W-1:0]   north;
        logic [SIZE_W-1:0]   south;
        logic [SIZE_W-1:0]   west;
        logic [SIZE_W-1:0]   east;
        logic [FRAC_MAX-1:0] fi;
        logic [FRAC_MAX-1:0] fj;
        logic [31:0]         pixel;
    } t_job;

    // One finished output pixel.
    typedef struct packed {
        logic [31:0] rgba;
        logic [8:0]  row;
        logic [8:0]  col;
        logic        bg;
    } t_result;

    // Source geometry and rotation registers seen by the front.
    typedef struct packed {
        logic [8:0]         src_height;
        logic [8:0]         src_width;
        logic [9:0]         res_height;
        logic [9:0]         res_width;
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
    } t_geom;

endpackage
`default_nettype wire

@@ sv/image_rotate_bilinear_core.sv @@
// Top level of the RGBA rotation core: registers, front, job queue, back, result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | push / full        | i_opcode, i_row, i_col, i_red_in .. i_alpha_in
//  result   | empty / pop        | o_red_out .. o_alpha_out, o_out_row, o_out_col,
//           |                    | o_is_background
//  config   | i_cfg_wr_en        | i_cfg_index, i_cfg_data
//
// One item is taken every cycle while full is low; a read request reaches the result side
// through the three front stages, the job queue, the store read, two blend stages and
// the result queue write. Writes give no result.
// Reset clears only control; the frame store holds garbage until written.
// Each side stalls on its own: full rises when the job queue plus the items still
// in the front stages reach the queue depth, and the back halts read issue when the
// result queue plus the reads in flight fill its slots; writes need no slot.
`default_nettype none
module image_rotate_bilinear_core #(
    parameter int MAX_SRC_HEIGHT  = irb_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_SRC_WIDTH   = irb_pkg::DEF_MAX_SRC_WIDTH,
    parameter int COORD_FRAC_BITS = irb_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input queue side
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_opcode,
    input  wire logic [8:0]                    i_row,
    input  wire logic [8:0]                    i_col,
    input  wire logic [7:0]                    i_red_in,
    input  wire logic [7:0]                    i_green_in,
    input  wire logic [7:0]                    i_blue_in,
    input  wire logic [7:0]                    i_alpha_in,
    // result queue side
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic [7:0]                         o_alpha_out,
    output logic [8:0]                         o_out_row,
    output logic [8:0]                         o_out_col,
    output logic                               o_is_background,
    // configuration writes
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [irb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    localparam int QCNT_W = $clog2(irb_pkg::Q_DEPTH + 1);
    localparam int OCNT_W = $clog2(irb_pkg::OUT_DEPTH + 1);

    // configuration registers
    irb_pkg::t_geom r_geom;
    logic [31:0]    r_background;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.src_height <= 9'd256;
            r_geom.src_width  <= 9'd256;
            r_geom.res_height <= 10'd256;
            r_geom.res_width  <= 10'd256;
            r_geom.cosine     <= 16'sd16384;
            r_geom.sine       <= 16'sd0;
            r_background      <= 32'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                irb_pkg::CFG_SRC_HEIGHT: r_geom.src_height <= i_cfg_data[8:0];
                irb_pkg::CFG_SRC_WIDTH:  r_geom.src_width  <= i_cfg_data[8:0];
                irb_pkg::CFG_RES_HEIGHT: r_geom.res_height <= i_cfg_data[9:0];
                irb_pkg::CFG_RES_WIDTH:  r_geom.res_width  <= i_cfg_data[9:0];
                irb_pkg::CFG_COSINE:     r_geom.cosine     <= signed'(i_cfg_data[15:0]);
                irb_pkg::CFG_SINE:       r_geom.sine       <= signed'(i_cfg_data[15:0]);
                irb_pkg::CFG_BACKGROUND: r_background      <= i_cfg_data;
                default: ; // drop writes past the register list
            endcase
        end
    end

    // front: coordinate mapping, credited against the job queue
    logic              w_in_xfer;
    logic              w_job_valid;
    irb_pkg::t_job     w_job_in, w_job_out;
    logic [1:0]        w_front_inflight;
    logic [QCNT_W-1:0] w_job_count;
    logic              w_job_empty, w_job_pop;

    assign w_in_xfer = push && !full;
    assign full = (5'(w_job_count) + 5'(w_front_inflight)) >= 5'(irb_pkg::Q_DEPTH);

    irb_front #(
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (r_geom),
        .i_valid   (w_in_xfer),
        .i_opcode  (i_opcode),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_pixel   ({i_alpha_in, i_blue_in, i_green_in, i_red_in}),
        .o_valid   (w_job_valid),
        .o_job     (w_job_in),
        .o_inflight(w_front_inflight)
    );

    irb_fifo #(.WIDTH($bits(irb_pkg::t_job)), .DEPTH(irb_pkg::Q_DEPTH)) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_valid),
        .i_data (w_job_in),
        .i_pop  (w_job_pop),
        .o_data (w_job_out),
        .o_count(w_job_count),
        .o_empty(w_job_empty)
    );

    // back: store access and blend, credited against the result queue
    logic              w_res_push;
    irb_pkg::t_result  w_res_in, w_res_out;
    logic [OCNT_W-1:0] w_res_count;

    irb_back #(
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_background(r_background),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_out_count (w_res_count),
        .o_push      (w_res_push),
        .o_result    (w_res_in)
    );

    irb_fifo #(.WIDTH($bits(irb_pkg::t_result)), .DEPTH(irb_pkg::OUT_DEPTH)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_in),
        .i_pop  (pop && !empty),
        .o_data (w_res_out),
        .o_count(w_res_count),
        .o_empty(empty)
    );

    // present the oldest result
    assign o_red_out       = w_res_out.rgba[7:0];
    assign o_green_out     = w_res_out.rgba[15:8];
    assign o_blue_out      = w_res_out.rgba[23:16];
    assign o_alpha_out     = w_res_out.rgba[31:24];
    assign o_out_row       = w_res_out.row;
    assign o_out_col       = w_res_out.col;
    assign o_is_background = w_res_out.bg;

endmodule
`default_nettype wire

@@ sv/irb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module irb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/irb_fifo.sv @@
// Small register queue; the writer keeps it from overflowing by credit.
`default_nettype none
module irb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic      [CNT_W-1:0] o_count,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign o_empty = (r_count == '0);

endmodule
`default_nettype wire

@@ sv/irb_front.sv @@
// Front: maps an output pixel back into the source and classifies it.
`default_nettype none
module irb_front #(
    parameter int MAX_SRC_HEIGHT  = irb_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_SRC_WIDTH   = irb_pkg::DEF_MAX_SRC_WIDTH,
    parameter int COORD_FRAC_BITS = irb_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire irb_pkg::t_geom i_geom,
    input  wire logic           i_valid,
    input  wire logic           i_opcode,
    input  wire logic [8:0]     i_row,
    input  wire logic [8:0]     i_col,
    input  wire logic [31:0]    i_pixel,
    output logic                o_valid,
    output irb_pkg::t_job       o_job,
    output logic [1:0]          o_inflight
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int SW     = irb_pkg::SIZE_W;
    localparam int PROD_W = 27;
    localparam int SUM_W  = 28;
    localparam int SHL    = (F > irb_pkg::TRIG_FRAC) ? F - irb_pkg::TRIG_FRAC : 0;
    localparam int SHR    = (F < irb_pkg::TRIG_FRAC) ? irb_pkg::TRIG_FRAC - F : 0;
    localparam int CW     = (((SUM_W + SHL) > (13 + F)) ? (SUM_W + SHL) : (13 + F)) + 1;

    // stage 1: centred offsets and effective source size
    logic               r_v1, r_op1;
    logic [8:0]         r_row1, r_col1;
    logic [31:0]        r_pix1;
    logic signed [10:0] r_di1, r_dj1;
    logic [SW-1:0]      r_h1, r_w1;
    logic signed [10:0] n_di, n_dj;
    logic [SW-1:0]      n_h, n_w;

    always_comb begin
        n_di = signed'({2'b00, i_row}) - signed'({2'b00, i_geom.res_height[9:1]});
        n_dj = signed'({2'b00, i_col}) - signed'({2'b00, i_geom.res_width[9:1]});
        n_h  = SW'(i_geom.src_height);
        if (n_h == '0) begin
            n_h = SW'(1);
        end else if (n_h > SW'(MAX_SRC_HEIGHT)) begin
            n_h = SW'(MAX_SRC_HEIGHT);
        end
        n_w  = SW'(i_geom.src_width);
        if (n_w == '0) begin
            n_w = SW'(1);
        end else if (n_w > SW'(MAX_SRC_WIDTH)) begin
            n_w = SW'(MAX_SRC_WIDTH);
        end
    end

    // stage 2: four rotation products
    logic                     r_v2, r_op2;
    logic [8:0]               r_row2, r_col2;
    logic [31:0]              r_pix2;
    logic [SW-1:0]            r_h2, r_w2;
    logic signed [PROD_W-1:0] r_cdi2, r_sdj2, r_cdj2, r_sdi2;

    // stage 3: source coordinates with F fraction bits
    logic                 r_v3, r_op3;
    logic [8:0]           r_row3, r_col3;
    logic [31:0]          r_pix3;
    logic [SW-1:0]        r_h3, r_w3;
    logic signed [CW-1:0] r_si3, r_sj3;
    logic signed [SUM_W-1:0] n_sum_i, n_sum_j;
    logic signed [CW-1:0]    n_si, n_sj;

    always_comb begin
        n_sum_i = SUM_W'(r_cdi2) + SUM_W'(r_sdj2);
        n_sum_j = SUM_W'(r_cdj2) - SUM_W'(r_sdi2);
        n_si = ((CW'(n_sum_i) <<< SHL) >>> SHR)
             + signed'(CW'({r_h2[SW-1:1], F'(0)}));
        n_sj = ((CW'(n_sum_j) <<< SHL) >>> SHR)
             + signed'(CW'({r_w2[SW-1:1], F'(0)}));
    end

    always_ff @(posedge i_clk) begin
        r_op1  <= i_opcode;
        r_row1 <= i_row;
        r_col1 <= i_col;
        r_pix1 <= i_pixel;
        r_di1  <= n_di;
        r_dj1  <= n_dj;
        r_h1   <= n_h;
        r_w1   <= n_w;

        r_op2  <= r_op1;
        r_row2 <= r_row1;
        r_col2 <= r_col1;
        r_pix2 <= r_pix1;
        r_h2   <= r_h1;
        r_w2   <= r_w1;
        r_cdi2 <= PROD_W'(i_geom.cosine) * PROD_W'(r_di1);
        r_sdj2 <= PROD_W'(i_geom.sine)   * PROD_W'(r_dj1);
        r_cdj2 <= PROD_W'(i_geom.cosine) * PROD_W'(r_dj1);
        r_sdi2 <= PROD_W'(i_geom.sine)   * PROD_W'(r_di1);

        r_op3  <= r_op2;
        r_row3 <= r_row2;
        r_col3 <= r_col2;
        r_pix3 <= r_pix2;
        r_h3   <= r_h2;
        r_w3   <= r_w2;
        r_si3  <= n_si;
        r_sj3  <= n_sj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // classify: outside test, neighbour rows and columns, weights
    logic [SW-1:0] w_n, w_s, w_wc, w_e;
    logic [F-1:0]  w_fi, w_fj;
    logic          w_bg;

    always_comb begin
        w_bg = r_si3 < 0 || r_sj3 < 0
            || r_si3 >= signed'(CW'({r_h3, F'(0)}))
            || r_sj3 >= signed'(CW'({r_w3, F'(0)}));
        w_n  = r_si3[F +: SW];
        w_wc = r_sj3[F +: SW];
        w_fi = r_si3[F-1:0];
        w_fj = r_sj3[F-1:0];
        w_s  = w_n + SW'(w_fi != '0);
        w_e  = w_wc + SW'(w_fj != '0);
        if (w_s > r_h3 - 1'b1) begin
            w_s = r_h3 - 1'b1;
        end
        if (w_e > r_w3 - 1'b1) begin
            w_e = r_w3 - 1'b1;
        end
    end

    always_comb begin
        o_job.is_write = (r_op3 == irb_pkg::OP_WRITE);
        o_job.row      = r_row3;
        o_job.col      = r_col3;
        o_job.bg       = w_bg;
        o_job.north    = w_n;
        o_job.south    = w_s;
        o_job.west     = w_wc;
        o_job.east     = w_e;
        o_job.fi       = irb_pkg::FRAC_MAX'(w_fi);
        o_job.fj       = irb_pkg::FRAC_MAX'(w_fj);
        o_job.pixel    = r_pix3;
    end

    assign o_valid    = r_v3;
    assign o_inflight = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);

endmodule
`default_nettype wire

@@ sv/irb_back.sv @@
// Back: frame store access and bilinear blend of the four neighbours.
`default_nettype none
module irb_back #(
    parameter int MAX_SRC_HEIGHT  = irb_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_SRC_WIDTH   = irb_pkg::DEF_MAX_SRC_WIDTH,
    parameter int COORD_FRAC_BITS = irb_pkg::DEF_COORD_FRAC_BITS,
    localparam int OCNT_W         = $clog2(irb_pkg::OUT_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [31:0]       i_background,
    input  wire logic              i_job_empty,
    input  wire irb_pkg::t_job     i_job,
    output logic                   o_job_pop,
    input  wire logic [OCNT_W-1:0] i_out_count,
    output logic                   o_push,
    output irb_pkg::t_result       o_result
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int DEPTH = MAX_SRC_HEIGHT * MAX_SRC_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = F + 8;
    localparam int VW    = 2 * F + 8;
    localparam int BW    = OCNT_W + 1;

    logic r_v1, r_v2, r_v3;
    logic [BW-1:0] w_busy;

    // issue: writes need no room; reads need a free result slot
    assign w_busy    = BW'(i_out_count) + BW'(r_v1) + BW'(r_v2) + BW'(r_v3);
    assign o_job_pop = !i_job_empty
                    && (i_job.is_write || w_busy < BW'(irb_pkg::OUT_DEPTH));

    logic          w_we;
    logic [AW-1:0] w_waddr, w_a_nw, w_a_ne, w_a_sw, w_a_se;

    assign w_we = o_job_pop && i_job.is_write
               && int'(i_job.row) < MAX_SRC_HEIGHT && int'(i_job.col) < MAX_SRC_WIDTH;
    assign w_waddr = AW'(int'(i_job.row)   * MAX_SRC_WIDTH + int'(i_job.col));
    assign w_a_nw  = AW'(int'(i_job.north) * MAX_SRC_WIDTH + int'(i_job.west));
    assign w_a_ne  = AW'(int'(i_job.north) * MAX_SRC_WIDTH + int'(i_job.east));
    assign w_a_sw  = AW'(int'(i_job.south) * MAX_SRC_WIDTH + int'(i_job.west));
    assign w_a_se  = AW'(int'(i_job.south) * MAX_SRC_WIDTH + int'(i_job.east));

    // one copy of the frame store per neighbour, all written alike
    logic [31:0] w_nw, w_ne, w_sw, w_se;

    irb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_nw (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_job.pixel),
        .i_raddr(w_a_nw), .o_rdata(w_nw));
    irb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_ne (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_job.pixel),
        .i_raddr(w_a_ne), .o_rdata(w_ne));
    irb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_sw (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_job.pixel),
        .i_raddr(w_a_sw), .o_rdata(w_sw));
    irb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_se (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_job.pixel),
        .i_raddr(w_a_se), .o_rdata(w_se));

    // stage 1: read data in flight
    logic         r_bg1, r_bg2, r_bg3;
    logic [8:0]   r_row1, r_col1, r_row2, r_col2, r_row3, r_col3;
    logic [F-1:0] r_fi1, r_fj1, r_fi2;
    logic [TW-1:0] r_top2 [4];
    logic [TW-1:0] r_bot2 [4];
    logic [31:0]   r_rgba3;

    logic [F:0]    w_wfj, w_wfi;
    logic [TW-1:0] n_top [4];
    logic [TW-1:0] n_bot [4];
    logic [VW-1:0] n_v [4];
    logic [31:0]   n_rgba;

    assign w_wfj = (F+1)'(1 << F) - {1'b0, r_fj1};
    assign w_wfi = (F+1)'(1 << F) - {1'b0, r_fi2};

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_top[c] = TW'(w_wfj) * TW'(w_nw[8*c +: 8]) + TW'(r_fj1) * TW'(w_ne[8*c +: 8]);
            n_bot[c] = TW'(w_wfj) * TW'(w_sw[8*c +: 8]) + TW'(r_fj1) * TW'(w_se[8*c +: 8]);
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_v[c] = VW'(w_wfi) * VW'(r_top2[c]) + VW'(r_fi2) * VW'(r_bot2[c]);
            n_rgba[8*c +: 8] = n_v[c][2*F +: 8];
        end
        if (r_bg2) begin
            n_rgba = i_background;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bg1  <= i_job.bg;
        r_row1 <= i_job.row;
        r_col1 <= i_job.col;
        r_fi1  <= i_job.fi[F-1:0];
        r_fj1  <= i_job.fj[F-1:0];

        r_bg2  <= r_bg1;
        r_row2 <= r_row1;
        r_col2 <= r_col1;
        r_fi2  <= r_fi1;
        r_top2 <= n_top;
        r_bot2 <= n_bot;

        r_bg3   <= r_bg2;
        r_row3  <= r_row2;
        r_col3  <= r_col2;
        r_rgba3 <= n_rgba;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_job_pop && !i_job.is_write;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_push        = r_v3;
    assign o_result.rgba = r_rgba3;
    assign o_result.row  = r_row3;
    assign o_result.col  = r_col3;
    assign o_result.bg   = r_bg3;

endmodule
`default_nettype wire

@@ sim/tb_image_rotate_bilinear_core.sv @@
// Self-checking testbench of the RGBA rotation core with inverse mapping and bilinear blend.
`timescale 1ns / 1ps
`default_nettype none
module tb_image_rotate_bilinear_core;

    localparam int MAX_H   = 256;
    localparam int MAX_W   = 256;
    localparam int FB      = 8;      // coordinate fraction bits
    localparam int LATENCY = 9;
    localparam int READS_PER_PHASE = 40;
    localparam int HOLD_CYCLES     = 300;
    // an index past the register list
    localparam logic [irb_pkg::CFG_IDX_W-1:0] CFG_PAST_END = 3'd7;

    // one pending input transfer
    typedef struct packed {
        logic       op;
        logic [8:0] row;
        logic [8:0] col;
        logic [7:0] r, g, b, a;
    } t_pix_req;

    // one predicted output pixel
    typedef struct packed {
        logic [7:0] r, g, b, a;
        logic [8:0] row;
        logic [8:0] col;
        logic       bg;
    } t_pix_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_opcode = 1'b0;
    logic [8:0] i_row = '0, i_col = '0;
    logic [7:0] i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_alpha_in = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_red_out, o_green_out, o_blue_out, o_alpha_out;
    logic [8:0] o_out_row, o_out_col;
    logic       o_is_background;
    logic                          i_cfg_wr_en = 1'b0;
    logic [irb_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data = '0;

    image_rotate_bilinear_core uut (
        .i_clk, .i_rst_n, .push, .full, .i_opcode, .i_row, .i_col,
        .i_red_in, .i_green_in, .i_blue_in, .i_alpha_in,
        .empty, .pop, .o_red_out, .o_green_out, .o_blue_out, .o_alpha_out,
        .o_out_row, .o_out_col, .o_is_background,
        .i_cfg_wr_en, .i_cfg_index, .i_cfg_data
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state: its own copy of the frame store and registers.
    logic [31:0] frame_mem [0:MAX_H*MAX_W-1];
    logic [8:0]  src_h_reg, src_w_reg;
    logic [9:0]  res_h_reg, res_w_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic [31:0] bg_reg;

    t_pix_req pending_pixels[$];
    t_pix_res expected_pixels[$];
    int       mismatches = 0;
    int       pixels_checked = 0;
    int       bg_pixels = 0;
    int       reads_sent = 0;
    bit       rx_hold = 1'b0;        // receiver holds off while set
    bit       rx_hold_req = 1'b0;    // starts the long hold-off
    bit       tx_taken = 1'b0;       // input transfer at the last rising edge
    bit       rx_taken = 1'b0;       // result transfer at the last rising edge

    // Sign-aware floor division of a Q14 product sum down to FB fraction bits.
    function automatic longint q14_to_coord(longint v);
        return v >>> (irb_pkg::TRIG_FRAC - FB);
    endfunction

    // Compute the rotated pixel for one read request, in store order RGBA.
    function automatic t_pix_res rotate_pixel(logic [8:0] row, logic [8:0] col);
        t_pix_res res;
        longint   h, w, di, dj, si, sj, fi, fj, n, wc, s, e, one;
        longint   top, bot, v;
        logic [31:0] nw, ne, sw, se, px;
        h   = (src_h_reg == 0) ? 1 : (src_h_reg > MAX_H ? MAX_H : src_h_reg);
        w   = (src_w_reg == 0) ? 1 : (src_w_reg > MAX_W ? MAX_W : src_w_reg);
        one = 1 << FB;
        di  = longint'(row) - longint'(res_h_reg / 2);
        dj  = longint'(col) - longint'(res_w_reg / 2);
        si  = q14_to_coord(cos_reg * di + sin_reg * dj) + (h / 2) * one;
        sj  = q14_to_coord(cos_reg * dj - sin_reg * di) + (w / 2) * one;
        res.row = row;
        res.col = col;
        res.bg  = (si < 0 || sj < 0 || si >= h * one || sj >= w * one);
        if (res.bg) begin
            px = bg_reg;
        end else begin
            n  = si >>> FB;
            wc = sj >>> FB;
            fi = si & (one - 1);
            fj = sj & (one - 1);
            s  = n + (fi != 0);
            e  = wc + (fj != 0);
            if (s > h - 1) s = h - 1;
            if (e > w - 1) e = w - 1;
            nw = frame_mem[n * MAX_W + wc];
            ne = frame_mem[n * MAX_W + e];
            sw = frame_mem[s * MAX_W + wc];
            se = frame_mem[s * MAX_W + e];
            for (int c = 0; c < 4; c++) begin
                top = (one - fj) * nw[8*c +: 8] + fj * ne[8*c +: 8];
                bot = (one - fj) * sw[8*c +: 8] + fj * se[8*c +: 8];
                v   = ((one - fi) * top + fi * bot) >> (2 * FB);
                px[8*c +: 8] = v[7:0];
            end
        end
        {res.a, res.b, res.g, res.r} = px;
        return res;
    endfunction

    // Record the handshakes of each rising edge for the negedge processes.
    always @(posedge i_clk) begin
        tx_taken <= i_rst_n && push && !full;
        rx_taken <= i_rst_n && pop && !empty;
    end

    // Driver: hold an item until taken, then wait a random gap before the next.
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || tx_taken) begin
            if (push) begin
                void'(pending_pixels.pop_front());
                tx_gap = $urandom_range(0, 8);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                push       <= 1'b1;
                i_opcode   <= pending_pixels[0].op;
                i_row      <= pending_pixels[0].row;
                i_col      <= pending_pixels[0].col;
                i_red_in   <= pending_pixels[0].r;
                i_green_in <= pending_pixels[0].g;
                i_blue_in  <= pending_pixels[0].b;
                i_alpha_in <= pending_pixels[0].a;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Predict at the accepting edge, in transfer order.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            if (i_opcode == irb_pkg::OP_WRITE) begin
                frame_mem[{i_row[7:0], i_col[7:0]}] <=
                    (i_row < MAX_H && i_col < MAX_W)
                    ? {i_alpha_in, i_blue_in, i_green_in, i_red_in}
                    : frame_mem[{i_row[7:0], i_col[7:0]}];
            end else begin
                expected_pixels.push_back(rotate_pixel(i_row, i_col));
                reads_sent <= reads_sent + 1;
            end
        end
    end

    // Long hold-off on the result side, counted here.
    always @(posedge rx_hold_req) begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Receiver: random gap after each transfer, idle during the hold-off.
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            pop <= 1'b0;
        end else if (!pop || rx_taken) begin
            if (rx_taken) begin
                rx_gap = $urandom_range(0, 8);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Monitor: compare each popped pixel against the oldest prediction.
    always @(posedge i_clk) begin
        t_pix_res want, got;
        if (i_rst_n && pop && !empty) begin
            got = '{o_red_out, o_green_out, o_blue_out, o_alpha_out,
                    o_out_row, o_out_col, o_is_background};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected pixel row %0d col %0d", got.row, got.col);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (want.bg) bg_pixels++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: pixel (%0d,%0d) exp rgba %h %h %h %h bg %0d,",
                                  " got (%0d,%0d) rgba %h %h %h %h bg %0d"},
                                 want.row, want.col, want.r, want.g, want.b, want.a,
                                 want.bg, got.row, got.col, got.r, got.g, got.b, got.a,
                                 got.bg);
                end
            end
        end
    end

    // Register write while the core is idle; the predictor copy follows.
    task automatic write_reg(logic [irb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            irb_pkg::CFG_SRC_HEIGHT: src_h_reg = val[8:0];
            irb_pkg::CFG_SRC_WIDTH:  src_w_reg = val[8:0];
            irb_pkg::CFG_RES_HEIGHT: res_h_reg = val[9:0];
            irb_pkg::CFG_RES_WIDTH:  res_w_reg = val[9:0];
            irb_pkg::CFG_COSINE:     cos_reg   = val[15:0];
            irb_pkg::CFG_SINE:       sin_reg   = val[15:0];
            irb_pkg::CFG_BACKGROUND: bg_reg    = val;
            default: ;
        endcase
    endtask

    // Hold until everything queued is sent and every prediction has come back.
    task automatic drain();
        while (pending_pixels.size() > 0 || push || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic queue_write(int row, int col, logic [31:0] px);
        pending_pixels.push_back('{irb_pkg::OP_WRITE, row[8:0], col[8:0],
                                   px[7:0], px[15:8], px[23:16], px[31:24]});
    endtask

    task automatic queue_read(int row, int col);
        t_pix_req it;
        it.op  = irb_pkg::OP_READ;
        it.row = row[8:0];
        it.col = col[8:0];
        {it.r, it.g, it.b, it.a} = $urandom;
        pending_pixels.push_back(it);
    endtask

    // Fill the source area with random pixels so that no read sees an unwritten entry.
    task automatic fill_source(int h, int w);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                queue_write(r, c, $urandom);
    endtask

    // Apply one geometry setting; source sizes stay small to keep fills short.
    task automatic set_geometry(int sh, int sw, int rh, int rw, int cs, int sn, logic [31:0] bg);
        write_reg(irb_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(irb_pkg::CFG_SRC_WIDTH,  sw);
        write_reg(irb_pkg::CFG_RES_HEIGHT, rh);
        write_reg(irb_pkg::CFG_RES_WIDTH,  rw);
        write_reg(irb_pkg::CFG_COSINE,     cs);
        write_reg(irb_pkg::CFG_SINE,       sn);
        write_reg(irb_pkg::CFG_BACKGROUND, bg);
    endtask

    initial begin
        int sh, sw, ang;
        int cos_tab [8];
        int sin_tab [8];
        cos_tab = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
        sin_tab = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};
        src_h_reg = 256; src_w_reg = 256; res_h_reg = 256; res_w_reg = 256;
        cos_reg = 16384; sin_reg = 0; bg_reg = 0;
        for (int k = 0; k < MAX_H*MAX_W; k++) frame_mem[k] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tiny 2x3 source, identity, then corner and edge reads.
        set_geometry(2, 3, 2, 3, 16384, 0, 32'hA1B2C3D4);
        fill_source(2, 3);
        queue_write(511, 511, 32'hFFFFFFFF);   // out of store range: ignored
        queue_write(256, 0, 32'h0);
        queue_read(0, 0);
        queue_read(1, 2);
        queue_read(511, 511);                  // far outside: background
        queue_read(0, 511);
        queue_read(511, 0);
        drain();
        // Half-pixel shift via odd result size, cosine -1.0 with sine 1.0, extreme registers.
        set_geometry(0, 0, 1, 1, -16384, 16384, 32'h00000000);   // zero sizes count as 1
        queue_read(0, 0);
        queue_read(1, 1);
        drain();
        write_reg(irb_pkg::CFG_SRC_HEIGHT, 511);   // saturates to 256; cover every size bit
        write_reg(irb_pkg::CFG_SRC_WIDTH,  511);
        write_reg(irb_pkg::CFG_RES_HEIGHT, 1023);
        write_reg(irb_pkg::CFG_RES_WIDTH,  512);
        write_reg(irb_pkg::CFG_COSINE,     32'hFFFF8000);
        write_reg(irb_pkg::CFG_SINE,       32'h00007FFF);
        write_reg(irb_pkg::CFG_BACKGROUND, 32'hFFFFFFFF);
        // only background can result here without touching unwritten entries
        queue_read(0, 0);
        queue_read(0, 511);
        drain();
        write_reg(CFG_PAST_END, 32'h12345678);   // index beyond the list: ignored

        // Random phases: small sources, random rotation, mostly reads.
        for (int ph = 0; ph < 8; ph++) begin
            sh  = (ph == 7) ? 1 : $urandom_range(2, 12);
            sw  = (ph == 6) ? 1 : $urandom_range(2, 12);
            ang = $urandom_range(0, 7);
            set_geometry(sh, sw, $urandom_range(1, 24), $urandom_range(1, 24),
                         (ph == 0) ? 16384 : cos_tab[ang] + $signed($urandom_range(0, 40)) - 20,
                         (ph == 1) ? -16384 : sin_tab[ang], $urandom);
            fill_source(sh, sw);
            for (int k = 0; k < READS_PER_PHASE; k++) begin
                if ($urandom_range(0, 9) == 0) queue_write($urandom_range(0, 511),
                                                           $urandom_range(0, 511), $urandom);
                else if ($urandom_range(0, 9) == 0)
                    queue_read($urandom_range(0, 511), $urandom_range(0, 511));
                else queue_read($urandom_range(0, 23), $urandom_range(0, 23));
            end
            if (ph == 3) begin
                // long hold-off on the result side so the core backs up
                rx_hold_req = 1'b1;
            end
            drain();                           // sender pauses until all results are in
        end
        drain();
        $display("Checked %0d output pixels (%0d background) over %0d read requests,",
                 pixels_checked, bg_pixels, reads_sent);
        $display("across directed corner cases and eight random rotation settings.");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
sv/irb_pkg.sv
sv/irb_ram.sv
sv/irb_fifo.sv
sv/irb_front.sv
sv/irb_back.sv
sv/image_rotate_bilinear_core.sv
sim/tb_image_rotate_bilinear_core.sv
